// ===== rtl/core/analog_channel_scaler_top_defines.svh =====
// ----------------------------------------------------------------------------
// analog channel scaler assertion macros
// shared assertion wrappers used by the port checker
// ----------------------------------------------------------------------------
`ifndef ANALOG_CHANNEL_SCALER_TOP_DEFINES_SVH
`define ANALOG_CHANNEL_SCALER_TOP_DEFINES_SVH

// property checked on every clock while out of reset
`define ACS_ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("acs assertion failed");

// property checked on every clock, reset included
`define ACS_ASSERT_ANY(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("acs assertion failed");

`endif

// ===== rtl/core/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg
// shared constants, types and helpers of the analog channel scaler
// ----------------------------------------------------------------------------
`default_nettype none

package acs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ADC_BITS  = 12;
    localparam int ADC_MAX   = (1 << ADC_BITS) - 1;

    // sample times full scale
    localparam int FS_W = 5;
    localparam int V_W  = ADC_BITS + FS_W;

    // 2^FRAC_BITS = SCL_A * ADC_MAX + SCL_B
    localparam int SCL_A = (1 << FRAC_BITS) / ADC_MAX;
    localparam int SCL_B = (1 << FRAC_BITS) % ADC_MAX;
    localparam int W_W   = V_W + ADC_BITS;

    // reciprocal of ADC_MAX for the remainder term
    localparam int RCP_SH = W_W;
    localparam int RCP_W  = W_W - ADC_BITS + 1;
    localparam longint unsigned RCP = (64'd1 << RCP_SH) / ADC_MAX;
    localparam int PR_W   = W_W + RCP_W;

    localparam int SENS_W  = FRAC_BITS + FS_W + 1;
    localparam int DEG_LIM = (1 << FRAC_BITS) / 10000;

    // divider geometry
    localparam int DW = 33;
    localparam int NW = 2 * DW;
    localparam int QW = 35;

    localparam logic signed [31:0] ENG_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] ENG_MIN = 32'sh80000000;

    // input modes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_1V   = 2'd1;
    localparam logic [1:0] MODE_10V  = 2'd2;
    localparam logic [1:0] MODE_20MA = 2'd3;

    localparam logic [FS_W-1:0] FS_1V   = 5'd1;
    localparam logic [FS_W-1:0] FS_10V  = 5'd10;
    localparam logic [FS_W-1:0] FS_20MA = 5'd20;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOANA = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // register indexes
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_LOW_SENS = 3'd1;
    localparam logic [2:0] REG_HIGH_SENS = 3'd2;
    localparam logic [2:0] REG_LOW_ENG  = 3'd3;
    localparam logic [2:0] REG_UPPER_ENG = 3'd4;
    localparam logic [2:0] REG_OFFSET   = 3'd5;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] low_sensor;
        logic signed [31:0] high_sensor;
        logic signed [31:0] low_eng;
        logic signed [31:0] upper_eng;
        logic signed [31:0] offset;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         cls;
        logic signed [DW-1:0] diff;
    } t_item;

    function automatic logic [DW-1:0] acs_sub(input logic [31:0] a, input logic [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    function automatic logic [DW-1:0] acs_mag(input logic [DW-1:0] x);
        return x[DW-1] ? (~x + DW'(1)) : x;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acs_front.sv =====
// ----------------------------------------------------------------------------
// acs_front
// accepts samples, classifies them and scales them to sensor units
// ----------------------------------------------------------------------------
`default_nettype none

module acs_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire acs_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [acs_pkg::ADC_BITS-1:0]  i_sample,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output acs_pkg::t_item                     o_item
);

    logic                                 en;
    logic [acs_pkg::FS_W-1:0]             fs;
    logic [acs_pkg::V_W-1:0]              v1;
    logic [acs_pkg::DW-1:0]               span_mag;
    logic [1:0]                           cls1;
    logic [acs_pkg::PR_W-1:0]             prod2;
    logic [acs_pkg::W_W-1:0]              rem3;
    logic [acs_pkg::SENS_W-1:0]           sens3;

    logic                                 r_v1, r_v2, r_v3;
    logic [1:0]                           r_cls1, r_cls2;
    logic [acs_pkg::W_W-1:0]              r_w1, r_w2;
    logic [acs_pkg::SENS_W-1:0]           r_lin1, r_lin2;
    logic [acs_pkg::V_W-1:0]              r_qe2;
    acs_pkg::t_item                       r_item;

    assign en      = !r_v3 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v3;
    assign o_item  = r_item;

    always_comb begin
        case (i_cfg.mode)
            acs_pkg::MODE_1V:  fs = acs_pkg::FS_1V;
            acs_pkg::MODE_10V: fs = acs_pkg::FS_10V;
            default:           fs = acs_pkg::FS_20MA;
        endcase
    end

    assign v1       = acs_pkg::V_W'(i_sample) * acs_pkg::V_W'(fs);
    assign span_mag = acs_pkg::acs_mag(acs_pkg::acs_sub(i_cfg.high_sensor, i_cfg.low_sensor));

    always_comb begin
        if (i_cfg.mode == acs_pkg::MODE_OFF) begin
            cls1 = acs_pkg::ST_NOANA;
        end else if (span_mag <= acs_pkg::DW'(acs_pkg::DEG_LIM)) begin
            cls1 = acs_pkg::ST_DEGEN;
        end else begin
            cls1 = acs_pkg::ST_OK;
        end
    end

    // quotient estimate of the remainder term, at most one low
    assign prod2 = acs_pkg::PR_W'(r_w1) * acs_pkg::PR_W'(acs_pkg::RCP);
    assign rem3  = r_w2 - acs_pkg::W_W'(r_qe2) * acs_pkg::W_W'(acs_pkg::ADC_MAX);
    assign sens3 = r_lin2 + acs_pkg::SENS_W'(r_qe2)
                 + acs_pkg::SENS_W'(rem3 >= acs_pkg::W_W'(acs_pkg::ADC_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cls1      <= cls1;
            r_w1        <= acs_pkg::W_W'(v1) * acs_pkg::W_W'(acs_pkg::SCL_B);
            r_lin1      <= acs_pkg::SENS_W'(v1) * acs_pkg::SENS_W'(acs_pkg::SCL_A);
            r_cls2      <= r_cls1;
            r_w2        <= r_w1;
            r_lin2      <= r_lin1;
            r_qe2       <= acs_pkg::V_W'(prod2 >> acs_pkg::RCP_SH);
            r_item.cls  <= r_cls2;
            r_item.diff <= $signed(acs_pkg::DW'(sens3))
                         - $signed({i_cfg.low_sensor[31], i_cfg.low_sensor});
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/acs_queue.sv =====
// ----------------------------------------------------------------------------
// acs_queue
// small queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module acs_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire acs_pkg::t_item  i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output acs_pkg::t_item       o_item
);

    acs_pkg::t_item  r_mem [0:3];
    logic [1:0]      r_wp, r_rp;
    logic [2:0]      r_cnt;
    logic            push, pop;

    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/acs_back.sv =====
// ----------------------------------------------------------------------------
// acs_back
// calibration product, pipelined divide, offset and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module acs_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire acs_pkg::t_cfg   i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire acs_pkg::t_item  i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic signed [31:0]   o_eng_value,
    output logic [1:0]           o_status
);

    localparam int DW = acs_pkg::DW;
    localparam int QW = acs_pkg::QW;
    localparam int NW = acs_pkg::NW;

    logic                 en;
    logic [DW-1:0]        span, span_mag, rise;
    logic [QW:0]          qmag;
    logic signed [QW+1:0] qs;
    logic signed [37:0]   sum;
    logic                 sat;

    // product stages
    logic                 r_v0, r_v1;
    logic [1:0]           r_cls0, r_cls1;
    logic                 r_neg0, r_neg1;
    logic [DW-1:0]        r_mr0, r_md0;
    logic [NW-1:0]        r_prod1;

    // divide stages, index 0 is the loaded numerator
    logic                 r_dv  [0:QW];
    logic [1:0]           r_dcls [0:QW];
    logic                 r_dneg [0:QW];
    logic                 r_dovf [0:QW];
    logic [DW-1:0]        r_rem [0:QW];
    logic [QW-1:0]        r_num [0:QW];
    logic [QW-1:0]        r_quo [0:QW];

    logic                 r_ov;
    logic signed [31:0]   r_eng;
    logic [1:0]           r_st;

    assign en       = !r_ov || i_ready;
    assign o_ready  = en;
    assign o_valid  = r_ov;
    assign o_eng_value = r_eng;
    assign o_status = r_st;

    assign span     = acs_pkg::acs_sub(i_cfg.high_sensor, i_cfg.low_sensor);
    assign span_mag = acs_pkg::acs_mag(span);
    assign rise     = acs_pkg::acs_sub(i_cfg.upper_eng, i_cfg.low_eng);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            for (int k = 0; k <= QW; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v0     <= i_valid;
            r_v1     <= r_v0;
            r_dv[0]  <= r_v1;
            for (int k = 0; k < QW; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_ov     <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DW:0] t;
        if (en) begin
            r_cls0  <= i_item.cls;
            r_neg0  <= rise[DW-1] ^ i_item.diff[DW-1] ^ span[DW-1];
            r_mr0   <= acs_pkg::acs_mag(rise);
            r_md0   <= acs_pkg::acs_mag(i_item.diff);

            r_cls1  <= r_cls0;
            r_neg1  <= r_neg0;
            r_prod1 <= NW'(r_mr0) * NW'(r_md0);

            // quotient of 2^QW or more saturates anyway
            r_dcls[0] <= r_cls1;
            r_dneg[0] <= r_neg1;
            r_dovf[0] <= DW'(r_prod1[NW-1:QW]) >= span_mag;
            r_rem[0]  <= DW'(r_prod1[NW-1:QW]);
            r_num[0]  <= r_prod1[QW-1:0];
            r_quo[0]  <= '0;

            for (int k = 0; k < QW; k++) begin
                t = {r_rem[k], r_num[k][QW-1]};
                r_dcls[k+1] <= r_dcls[k];
                r_dneg[k+1] <= r_dneg[k];
                r_dovf[k+1] <= r_dovf[k];
                r_num[k+1]  <= {r_num[k][QW-2:0], 1'b0};
                if (t >= {1'b0, span_mag}) begin
                    r_rem[k+1] <= DW'(t - {1'b0, span_mag});
                    r_quo[k+1] <= {r_quo[k][QW-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= DW'(t);
                    r_quo[k+1] <= {r_quo[k][QW-2:0], 1'b0};
                end
            end
        end
    end

    assign qmag = r_dovf[QW] ? ((QW+1)'(1) << QW) : {1'b0, r_quo[QW]};
    assign qs   = r_dneg[QW] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    assign sum  = $signed({{6{i_cfg.low_eng[31]}}, i_cfg.low_eng})
                + $signed({qs[QW+1], qs})
                + $signed({{6{i_cfg.offset[31]}}, i_cfg.offset});
    assign sat  = !((&sum[37:31]) || !(|sum[37:31]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            case (r_dcls[QW])
                acs_pkg::ST_NOANA: begin
                    r_eng <= '0;
                    r_st  <= acs_pkg::ST_NOANA;
                end
                acs_pkg::ST_DEGEN: begin
                    r_eng <= i_cfg.offset;
                    r_st  <= acs_pkg::ST_DEGEN;
                end
                default: begin
                    if (sat) begin
                        r_eng <= sum[37] ? acs_pkg::ENG_MIN : acs_pkg::ENG_MAX;
                        r_st  <= acs_pkg::ST_SAT;
                    end else begin
                        r_eng <= sum[31:0];
                        r_st  <= acs_pkg::ST_OK;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/analog_channel_scaler_top.sv =====
// ----------------------------------------------------------------------------
// analog_channel_scaler_top
// converts raw adc samples to calibrated engineering units
// ----------------------------------------------------------------------------
// The block takes one 12-bit converter sample per clock while o_in_ready
// is high and returns one signed Q16.16 engineering value plus a status
// code per sample, in order. The sample is scaled to the selected full
// scale (1 V, 10 V or 20 mA), mapped through the two-point calibration
// line and offset, and clamped to 32 bits. A sample passes three front
// scaling stages, the four-entry queue, two product stages, a divider load
// stage, 35 restoring divider stages (one quotient bit per stage) and the
// output register. The divider stages set the latency; the sustained rate
// is one sample per cycle while the output side takes transfers. The user
// must see that calibration registers are written only while idle; the
// block itself does not enforce this.
`default_nettype none

module analog_channel_scaler_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data,
    // sample channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [acs_pkg::ADC_BITS-1:0]  i_adc_sample,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [31:0]                 o_eng_value,
    output logic [1:0]                         o_status
);

    acs_pkg::t_cfg   r_cfg;
    acs_pkg::t_item  f_item, q_item;
    logic            f_valid, f_ready, q_valid, q_ready;

    // register writes always complete in one transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                acs_pkg::REG_MODE:      r_cfg.mode        <= i_cfg_data[1:0];
                acs_pkg::REG_LOW_SENS:  r_cfg.low_sensor  <= i_cfg_data;
                acs_pkg::REG_HIGH_SENS: r_cfg.high_sensor <= i_cfg_data;
                acs_pkg::REG_LOW_ENG:   r_cfg.low_eng     <= i_cfg_data;
                acs_pkg::REG_UPPER_ENG: r_cfg.upper_eng   <= i_cfg_data;
                acs_pkg::REG_OFFSET:    r_cfg.offset      <= i_cfg_data;
                default: ; // unused indexes are ignored
            endcase
        end
    end

    // front: mode check, degenerate check, scaling to sensor units
    acs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (i_adc_sample),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_item   (f_item)
    );

    // decouples the front from back-side stalls
    acs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    // back: calibration line, divide, offset, saturation
    acs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_item      (q_item),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_eng_value (o_eng_value),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

// ===== rtl/core/acs_checker.sv =====
// ----------------------------------------------------------------------------
// acs_checker
// port-level checks of the analog channel scaler
// ----------------------------------------------------------------------------
`default_nettype none

`include "analog_channel_scaler_top_defines.svh"

module acs_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [31:0] o_eng_value,
    input  wire logic [1:0]         o_status
);

    logic at_limit;

    // value sits on one of the clamp limits
    assign at_limit = (o_eng_value == acs_pkg::ENG_MAX) || (o_eng_value == acs_pkg::ENG_MIN);

    `ACS_ASSERT_ANY(a_reset_empty, !i_rst_n |=> !o_out_valid)
    `ACS_ASSERT_CLK(a_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_eng_value))
    `ACS_ASSERT_CLK(a_noana_zero, o_out_valid && o_status == acs_pkg::ST_NOANA |-> o_eng_value == 0)
    `ACS_ASSERT_CLK(a_sat_limit, o_out_valid && o_status == acs_pkg::ST_SAT |-> at_limit)

endmodule

bind analog_channel_scaler_top acs_checker u_acs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_eng_value (o_eng_value),
    .o_status    (o_status)
);

`default_nettype wire
